### design/framed_ring_frame_reader_core_macros.svh
// Assertion macros used by the checker file of the frame reader core.
`ifndef FRAMED_RING_FRAME_READER_CORE_MACROS_SVH
`define FRAMED_RING_FRAME_READER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define FRFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FRFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/frfr_pkg.sv
// Package: sizes, action codes and request/result types of the frame reader.
`timescale 1ns / 1ps
`default_nettype none
package frfr_pkg;

  localparam int RING_BYTES = 1024;
  localparam int ADDR_W     = $clog2(RING_BYTES);
  localparam int PTR_W      = ADDR_W + 1;
  localparam int HDR_BYTES  = 4;
  localparam int MAX_OUT    = 64;
  localparam int LIM_W      = 7;
  localparam int IDX_W      = $clog2(MAX_OUT);
  localparam int OFS_W      = 7;
  localparam int LEN_W      = 16;

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_INIT = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] push_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0]       op_code;
    logic [7:0]       payload_byte;
    logic             byte_valid;
    logic [LIM_W-1:0] frame_length;
    logic             last;
    logic             push_accepted;
  } out_res_t;

endpackage
`default_nettype wire

### design/frfr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module frfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### design/framed_ring_frame_reader_core.sv
// Top level: length-prefixed frame ring with push, pop and drop requests.
//
//  channel | ports                         | handshake
//  --------+-------------------------------+--------------------------------
//  request | start, busy, in_item          | taken when start & !busy
//  result  | out_strobe, out_item          | one cycle per result, no stall
//  config  | cfg_wr_en, cfg_wr_data        | written when cfg_wr_en
//
// Push, drop and ignored requests are answered without raising busy; the result
// shows in the next cycle while the next request may already be taken.
// A pop reads the header through the single RAM read port: busy stays high
// through the header states S_OP, S_LO and S_HI, then in S_STREAM while the
// payload bytes go out (not when nothing is delivered or no whole frame
// waits past the header). Each result shows in the cycle after it is formed.
// A pop with fewer than 4 bytes waiting gets an empty final result without raising busy.
// Reset (rst_n low, synchronous) empties the ring and sets the limit to 64.
// The result side cannot stall; every result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module framed_ring_frame_reader_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire frfr_pkg::in_req_t             in_item,
  output logic                               out_strobe,
  output frfr_pkg::out_res_t                 out_item,
  input  wire logic                          cfg_wr_en,
  input  wire logic [frfr_pkg::LIM_W-1:0]    cfg_wr_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_LO,
    S_HI,
    S_STREAM
  } state_t;

  state_t state_r, state_nxt;

  logic [frfr_pkg::PTR_W-1:0] wp_r, wp_nxt;
  logic [frfr_pkg::PTR_W-1:0] rp_r, rp_nxt;
  logic [frfr_pkg::LIM_W-1:0] limit_r;
  logic [7:0]                 op_r, op_nxt;
  logic [7:0]                 lo_r, lo_nxt;
  logic [frfr_pkg::PTR_W-1:0] len_r, len_nxt;
  logic [frfr_pkg::LIM_W-1:0] cnt_r, cnt_nxt;
  logic [frfr_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       strobe_r, strobe_nxt;
  frfr_pkg::out_res_t         res_r, res_nxt;

  logic                        accept;
  logic [frfr_pkg::PTR_W-1:0]  fill;
  logic                        full;
  logic                        hdr_ok;
  logic [frfr_pkg::LEN_W-1:0]  len_w;
  logic [frfr_pkg::LEN_W:0]    need;
  logic                        frame_ok;
  logic [frfr_pkg::LIM_W-1:0]  lim;
  logic [frfr_pkg::LIM_W-1:0]  deliv;
  logic [frfr_pkg::OFS_W-1:0]  rd_ofs;
  logic [frfr_pkg::PTR_W-1:0]  rd_ptr;
  logic [frfr_pkg::PTR_W-1:0]  len_sel;
  logic [frfr_pkg::PTR_W-1:0]  rp_adv;
  logic                        stream_last;
  logic                        ram_we;
  logic [7:0]                  rd_data;
  frfr_pkg::out_res_t          res_empty;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // Pointers run modulo twice the ring size, so the fill never aliases.
  assign fill     = wp_r - rp_r;
  assign full     = fill[frfr_pkg::PTR_W-1];
  assign hdr_ok   = (fill >= frfr_pkg::PTR_W'(frfr_pkg::HDR_BYTES));
  assign len_w    = {rd_data, lo_r};
  assign need     = {1'b0, len_w} + (frfr_pkg::LEN_W+1)'(frfr_pkg::HDR_BYTES);
  assign frame_ok = ((frfr_pkg::LEN_W+1)'(fill) >= need);
  assign lim      = (limit_r > frfr_pkg::LIM_W'(frfr_pkg::MAX_OUT)) ?
                    frfr_pkg::LIM_W'(frfr_pkg::MAX_OUT) : limit_r;
  assign deliv    = (len_w < frfr_pkg::LEN_W'(lim)) ? len_w[frfr_pkg::LIM_W-1:0] : lim;

  // Shared address adder: header bytes, then payload prefetched one ahead.
  always_comb begin
    unique case (state_r)
      S_IDLE:   rd_ofs = '0;
      S_OP:     rd_ofs = frfr_pkg::OFS_W'(2);
      S_LO:     rd_ofs = frfr_pkg::OFS_W'(3);
      S_HI:     rd_ofs = frfr_pkg::OFS_W'(frfr_pkg::HDR_BYTES);
      S_STREAM: rd_ofs = frfr_pkg::OFS_W'(idx_r) +
                         frfr_pkg::OFS_W'(frfr_pkg::HDR_BYTES + 1);
      default:  rd_ofs = '0;
    endcase
  end

  assign rd_ptr      = rp_r + frfr_pkg::PTR_W'(rd_ofs);
  assign len_sel     = (state_r == S_HI) ? len_w[frfr_pkg::PTR_W-1:0] : len_r;
  assign rp_adv      = rp_r + frfr_pkg::PTR_W'(frfr_pkg::HDR_BYTES) + len_sel;
  assign stream_last = ((frfr_pkg::LIM_W'(idx_r) + frfr_pkg::LIM_W'(1)) == cnt_r);
  assign ram_we      = accept && (in_item.action == frfr_pkg::ACT_PUSH) && !full;

  always_comb begin
    res_empty      = '0;
    res_empty.last = 1'b1;
  end

  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    op_nxt     = op_r;
    lo_nxt     = lo_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          strobe_nxt = 1'b1;
          res_nxt    = res_empty;
          case (in_item.action)
            frfr_pkg::ACT_PUSH: begin
              if (!full) begin
                wp_nxt                = wp_r + frfr_pkg::PTR_W'(1);
                res_nxt.push_accepted = 1'b1;
              end
            end
            frfr_pkg::ACT_POP: begin
              // Hold the answer until the header has been read.
              if (hdr_ok) begin
                strobe_nxt = 1'b0;
                state_nxt  = S_OP;
              end
            end
            frfr_pkg::ACT_INIT: begin
              rp_nxt = wp_r;
            end
            default: begin
            end
          endcase
        end
      end
      S_OP: begin
        op_nxt    = rd_data;
        state_nxt = S_LO;
      end
      S_LO: begin
        lo_nxt    = rd_data;
        state_nxt = S_HI;
      end
      S_HI: begin
        len_nxt    = len_w[frfr_pkg::PTR_W-1:0];
        cnt_nxt    = deliv;
        idx_nxt    = '0;
        if (!frame_ok) begin
          strobe_nxt = 1'b1;
          res_nxt    = res_empty;
          state_nxt  = S_IDLE;
        end else if (deliv == '0) begin
          strobe_nxt      = 1'b1;
          res_nxt         = res_empty;
          res_nxt.op_code = op_r;
          rp_nxt          = rp_adv;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_STREAM;
        end
      end
      S_STREAM: begin
        strobe_nxt           = 1'b1;
        res_nxt              = '0;
        res_nxt.op_code      = op_r;
        res_nxt.payload_byte = rd_data;
        res_nxt.byte_valid   = 1'b1;
        res_nxt.frame_length = cnt_r;
        res_nxt.last         = stream_last;
        idx_nxt              = idx_r + frfr_pkg::IDX_W'(1);
        if (stream_last) begin
          rp_nxt    = rp_adv;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wp_r     <= '0;
      rp_r     <= '0;
      limit_r  <= frfr_pkg::LIM_W'(frfr_pkg::MAX_OUT);
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
    op_r  <= op_nxt;
    lo_r  <= lo_nxt;
    len_r <= len_nxt;
    cnt_r <= cnt_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end

  frfr_ram #(
    .WIDTH (8),
    .DEPTH (frfr_pkg::RING_BYTES)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wp_r[frfr_pkg::ADDR_W-1:0]),
    .wr_data (in_item.push_byte),
    .rd_addr (rd_ptr[frfr_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign out_strobe = strobe_r;
  assign out_item   = res_r;

endmodule
`default_nettype wire

### design/framed_ring_frame_reader_core_chk.sv
// Port-level checker for the frame reader core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "framed_ring_frame_reader_core_macros.svh"
module framed_ring_frame_reader_core_chk (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire frfr_pkg::in_req_t          in_item,
  input wire logic                       out_strobe,
  input wire frfr_pkg::out_res_t         out_item,
  input wire logic                       cfg_wr_en
);

  logic push_req;

  assign push_req = start && !busy && (in_item.action == frfr_pkg::ACT_PUSH);

  // A push request answers in the very next cycle with a final result.
  `FRFR_ASSERT_NEXT(a_push_answers, push_req, out_strobe && out_item.last, "push not answered")

  // A result without a payload byte ends its request.
  `FRFR_ASSERT_NOW(a_nobyte_last, out_strobe && !out_item.byte_valid, out_item.last, "lone result not last")

  // A payload stream never breaks before its last byte.
  `FRFR_ASSERT_NEXT(a_stream_solid, out_strobe && out_item.byte_valid && !out_item.last, out_strobe && out_item.byte_valid, "payload stream broke")

  // Delivered bytes carry a nonzero length and never a push acknowledge.
  `FRFR_ASSERT_NOW(a_byte_fields, out_strobe && out_item.byte_valid, (out_item.frame_length != '0) && !out_item.push_accepted, "bad payload result fields")

  // The limit changes only while no request is in flight.
  `FRFR_ASSERT_NOW(a_cfg_idle, cfg_wr_en, !busy && !out_strobe, "limit written mid request")

endmodule
`default_nettype wire

bind framed_ring_frame_reader_core framed_ring_frame_reader_core_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_item     (in_item),
  .out_strobe  (out_strobe),
  .out_item    (out_item),
  .cfg_wr_en   (cfg_wr_en)
);

### tb/tb_top.sv
// Self-checking testbench of the frame ring reader core with a live predictor.
`timescale 1ns / 1ps
module tb_top;

  localparam int CLK_HALF     = 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;
  localparam int SETTLE_GAP   = 4;
  localparam int TAIL_CYCLES  = frfr_pkg::HDR_BYTES + frfr_pkg::MAX_OUT + 4;
  localparam int IDLE_PERCENT = 31;
  localparam int BIG_LEN      = frfr_pkg::MAX_OUT + 1;
  localparam logic [1:0] ACT_IGNORE = 2'd3;

  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       start       = 1'b0;
  frfr_pkg::in_req_t          in_item     = '0;
  logic                       cfg_wr_en   = 1'b0;
  logic [frfr_pkg::LIM_W-1:0] cfg_wr_data = '0;
  logic                       busy;
  logic                       out_strobe;
  frfr_pkg::out_res_t         out_item;

  // Shadow of the ring and its pointers, updated as each request is taken.
  logic [7:0]                 ring_mem [frfr_pkg::RING_BYTES];
  logic [frfr_pkg::PTR_W-1:0] wr_ptr_m = '0;
  logic [frfr_pkg::PTR_W-1:0] rd_ptr_m = '0;
  logic [frfr_pkg::LIM_W-1:0] limit_m  = 7'd64;

  frfr_pkg::in_req_t  req_q[$];
  frfr_pkg::out_res_t ring_results_q[$];
  frfr_pkg::out_res_t expected_res;
  int                 mismatches   = 0;
  int                 cycles       = 0;
  bit                 steady_drive = 1'b0;

  framed_ring_frame_reader_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_strobe  (out_strobe),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [7:0] ring_byte(input int unsigned offset);
    logic [frfr_pkg::PTR_W-1:0] p;
    p = rd_ptr_m + offset[frfr_pkg::PTR_W-1:0];
    return ring_mem[p[frfr_pkg::ADDR_W-1:0]];
  endfunction

  task automatic compute_ring_results(input frfr_pkg::in_req_t req);
    frfr_pkg::out_res_t         r;
    logic [frfr_pkg::PTR_W-1:0] fill;
    int unsigned                avail, len, lim, cnt, step;
    fill  = wr_ptr_m - rd_ptr_m;
    avail = 32'(fill);
    r      = '0;
    r.last = 1'b1;
    case (req.action)
      frfr_pkg::ACT_PUSH: begin
        if (avail < frfr_pkg::RING_BYTES) begin
          ring_mem[wr_ptr_m[frfr_pkg::ADDR_W-1:0]] = req.push_byte;
          wr_ptr_m        = wr_ptr_m + frfr_pkg::PTR_W'(1);
          r.push_accepted = 1'b1;
        end
        ring_results_q.push_back(r);
      end
      frfr_pkg::ACT_POP: begin
        if (avail < frfr_pkg::HDR_BYTES) begin
          ring_results_q.push_back(r);
        end else begin
          len = 32'({ring_byte(3), ring_byte(2)});
          if (avail < frfr_pkg::HDR_BYTES + len) begin
            // hold: the frame is not all here yet
            ring_results_q.push_back(r);
          end else begin
            lim = (32'(limit_m) > frfr_pkg::MAX_OUT) ? frfr_pkg::MAX_OUT : 32'(limit_m);
            cnt = (len < lim) ? len : lim;
            r.op_code = ring_byte(0);
            if (cnt == 0) begin
              ring_results_q.push_back(r);
            end else begin
              for (int i = 0; i < cnt; i++) begin
                r.payload_byte = ring_byte(frfr_pkg::HDR_BYTES + i);
                r.byte_valid   = 1'b1;
                r.frame_length = cnt[frfr_pkg::LIM_W-1:0];
                r.last         = (i == cnt - 1);
                ring_results_q.push_back(r);
              end
            end
            // drop the whole frame, truncated bytes included
            step     = frfr_pkg::HDR_BYTES + len;
            rd_ptr_m = rd_ptr_m + step[frfr_pkg::PTR_W-1:0];
          end
        end
      end
      frfr_pkg::ACT_INIT: begin
        rd_ptr_m = wr_ptr_m;
        ring_results_q.push_back(r);
      end
      default: begin
        ring_results_q.push_back(r);
      end
    endcase
  endtask

  // Request driver: predict on acceptance, then present the next request or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_item <= '0;
    end else if (!start || !busy) begin
      if (start) compute_ring_results(in_item);
      if (req_q.size() > 0 && (steady_drive || $urandom_range(99) >= IDLE_PERCENT)) begin
        start   <= 1'b1;
        in_item <= req_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor: every strobe must match the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (ring_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: op %02h byte %02h valid %0d len %0d last %0d acc %0d",
                   out_item.op_code, out_item.payload_byte, out_item.byte_valid,
                   out_item.frame_length, out_item.last, out_item.push_accepted);
      end else begin
        expected_res = ring_results_q.pop_front();
        if (out_item.op_code       !== expected_res.op_code      ||
            out_item.payload_byte  !== expected_res.payload_byte ||
            out_item.byte_valid    !== expected_res.byte_valid   ||
            out_item.frame_length  !== expected_res.frame_length ||
            out_item.last          !== expected_res.last         ||
            out_item.push_accepted !== expected_res.push_accepted) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch exp: op %02h byte %02h valid %0d len %0d last %0d acc %0d",
                     expected_res.op_code, expected_res.payload_byte,
                     expected_res.byte_valid, expected_res.frame_length,
                     expected_res.last, expected_res.push_accepted);
            $display("         got: op %02h byte %02h valid %0d len %0d last %0d acc %0d",
                     out_item.op_code, out_item.payload_byte, out_item.byte_valid,
                     out_item.frame_length, out_item.last, out_item.push_accepted);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("framed_ring_frame_reader_core regression: fail");
      $finish;
    end
  end

  task automatic add_req(input logic [1:0] act, input logic [7:0] data);
    frfr_pkg::in_req_t q;
    q.action    = act;
    q.push_byte = data;
    req_q.push_back(q);
  endtask

  // Queue a header plus 'sent' payload bytes; sent < len leaves the frame short.
  task automatic add_frame(input logic [7:0] op, input int unsigned len,
                           input int unsigned sent);
    add_req(frfr_pkg::ACT_PUSH, op);
    add_req(frfr_pkg::ACT_PUSH, 8'($urandom_range(255)));
    add_req(frfr_pkg::ACT_PUSH, len[7:0]);
    add_req(frfr_pkg::ACT_PUSH, len[15:8]);
    for (int i = 0; i < sent; i++) add_req(frfr_pkg::ACT_PUSH, 8'($urandom_range(255)));
  endtask

  // Wait until every request is taken and every result is in.
  task automatic settle();
    do @(negedge clk);
    while (req_q.size() != 0 || start || busy || ring_results_q.size() != 0);
    repeat (SETTLE_GAP) @(negedge clk);
  endtask

  task automatic write_limit(input logic [frfr_pkg::LIM_W-1:0] val);
    settle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_m = val;
    @(negedge clk);
  endtask

  // One frame longer than the most results, sent with no idling, popped, then an empty pop.
  task automatic big_frame();
    settle();
    steady_drive = 1'b1;
    add_frame(8'($urandom_range(255)), BIG_LEN, BIG_LEN);
    add_req(frfr_pkg::ACT_POP, 8'($urandom_range(255)));
    add_req(frfr_pkg::ACT_POP, 8'($urandom_range(255)));
    settle();
    steady_drive = 1'b0;
  endtask

  // Mostly whole frames then a pop; the rest short frames and noise, resynced by a drop.
  task automatic random_items(input int unsigned target);
    int unsigned added, base, kind, len;
    added = 0;
    while (added < target) begin
      base = req_q.size();
      kind = $urandom_range(99);
      if (kind < 70) begin
        len = $urandom_range(6);
        add_frame(8'($urandom_range(255)), len, len);
        add_req(frfr_pkg::ACT_POP, 8'($urandom_range(255)));
        if ($urandom_range(3) == 0) add_req(frfr_pkg::ACT_POP, 8'($urandom_range(255)));
      end else if (kind < 82) begin
        if ($urandom_range(1) == 0) begin
          repeat ($urandom_range(3, 1)) add_req(frfr_pkg::ACT_PUSH, 8'($urandom_range(255)));
        end else begin
          len = $urandom_range(65535);
          add_frame(8'($urandom_range(255)), len, (len < 3) ? 0 : $urandom_range(2));
        end
        add_req(frfr_pkg::ACT_POP, 8'($urandom_range(255)));
        add_req(frfr_pkg::ACT_INIT, 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(4, 1))
          add_req(2'($urandom_range(3)), 8'($urandom_range(255)));
        add_req(frfr_pkg::ACT_INIT, 8'($urandom_range(255)));
      end
      added += req_q.size() - base;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    // Directed: empty pop, ignored action, extremes, zero length, short frame, drop.
    add_req(frfr_pkg::ACT_POP, 8'h00);
    add_req(ACT_IGNORE, 8'hFF);
    add_frame(8'hFF, 2, 0);
    add_req(frfr_pkg::ACT_PUSH, 8'h00);
    add_req(frfr_pkg::ACT_PUSH, 8'hFF);
    add_req(frfr_pkg::ACT_POP, 8'hFF);
    add_frame(8'h00, 0, 0);
    add_req(frfr_pkg::ACT_POP, 8'h00);
    add_frame(8'h5A, 3, 1);
    add_req(frfr_pkg::ACT_POP, 8'h00);
    add_req(frfr_pkg::ACT_INIT, 8'h00);
    add_req(frfr_pkg::ACT_POP, 8'h00);
    add_req(frfr_pkg::ACT_PUSH, 8'hA5);
    add_req(frfr_pkg::ACT_POP, 8'h00);
    add_req(frfr_pkg::ACT_INIT, 8'h00);

    write_limit(7'd0);
    add_frame(8'hC3, 3, 3);
    add_req(frfr_pkg::ACT_POP, 8'h00);
    random_items(8);

    write_limit(7'd1);
    random_items(8);

    write_limit(7'd127);
    big_frame();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && ring_results_q.size() == 0) begin
      $display("framed_ring_frame_reader_core regression: pass");
    end else begin
      $display("framed_ring_frame_reader_core regression: fail");
    end
    $finish;
  end

endmodule
